// File: design/handheld_bus_address_decoder_defines.svh
// Assertion macros used by the checker file of the bus address decoder.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_DEFINES_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define HBAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bus address decoder check failed");

// Next-cycle implication, switched off while reset is high.
`define HBAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bus address decoder check failed");

// Checks the cycle after reset, so it stays live during reset.
`define HBAD_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("bus address decoder reset check failed");

`endif

// File: design/hbad_pkg.sv
`default_nettype none

package hbad_pkg;

  localparam int MAX_ROM_BANKS = 512;
  localparam int MAX_RAM_BANKS = 16;

  localparam int ROM_BANK_W  = $clog2(MAX_ROM_BANKS);
  localparam int ROM_PAGE_W  = 14;
  localparam int RAM_PAGE_W  = 13;
  localparam int RAM_BANK_W  = $clog2(MAX_RAM_BANKS);
  localparam int RAM_COUNT_W = 5;
  localparam int OFFSET_W    = 23;
  localparam int ADDR_W      = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONTROLLER_KIND = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BANK_MODE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_SIZE       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_ENABLED    = 3'd6;

  localparam logic [1:0] CTRL_TYPE_ONE = 2'd1;
  localparam logic [1:0] CTRL_TYPE_TWO = 2'd2;

  localparam logic [ROM_BANK_W-1:0]  ROM_LOW_BANK_MASK = ROM_BANK_W'(9'h060);
  localparam logic [RAM_COUNT_W-1:0] RAM_COUNT_MAX     = RAM_COUNT_W'(MAX_RAM_BANKS);

  localparam logic [ADDR_W-1:0] ADDR_VRAM       = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_EXT_RAM    = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_WORK_RAM   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_ECHO_RAM   = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_OAM        = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_PROHIBITED = 16'hFEA0;
  localparam logic [ADDR_W-1:0] ADDR_IO         = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_HIGH_RAM   = 16'hFF80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [3:0] {
    REG_ROM        = 4'd0,
    REG_BOOT       = 4'd1,
    REG_VRAM       = 4'd2,
    REG_EXT_RAM    = 4'd3,
    REG_WORK_RAM   = 4'd4,
    REG_OAM        = 4'd5,
    REG_PROHIBITED = 4'd6,
    REG_IO         = 4'd7,
    REG_HIGH_RAM   = 4'd8
  } region_t;

  typedef enum logic [1:0] {
    OP_DIRECT   = 2'd0,
    OP_ROM_BANK = 2'd1,
    OP_EXT_BANK = 2'd2,
    OP_UNMAPPED = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]             controller_kind;
    logic                   bank_mode;
    logic [ROM_BANK_W-1:0]  rom_bank;
    logic [RAM_BANK_W-1:0]  ram_bank;
    logic [RAM_COUNT_W-1:0] ram_bank_count;
    logic [11:0]            boot_size;
    logic                   boot_enabled;
  } cfg_t;

  // A classified access waiting for its offset to be built.
  typedef struct packed {
    region_t                region;
    op_t                    op;
    logic [ROM_BANK_W-1:0]  bank;
    logic [RAM_COUNT_W-1:0] count;
    logic [ADDR_W-1:0]      local_addr;
  } item_t;

  typedef struct packed {
    region_t             region;
    logic [OFFSET_W-1:0] offset;
    logic                mapped;
  } result_t;

  // Remainder of a RAM bank number by the fitted bank count, one bit per step.
  function automatic logic [RAM_BANK_W-1:0] ram_bank_wrap(
    input logic [RAM_BANK_W-1:0]  bank,
    input logic [RAM_COUNT_W-1:0] count
  );
    logic [RAM_COUNT_W-1:0] rem;
    rem = '0;
    for (int i = RAM_BANK_W - 1; i >= 0; i--) begin
      rem = {rem[RAM_COUNT_W-2:0], bank[i]};
      if (rem >= count) begin
        rem = rem - count;
      end
    end
    return rem[RAM_BANK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/handheld_bus_address_decoder.sv
// A pushed address is registered in the input queue, then its result in the result queue.
// Throughput: one address per cycle while full is low; a push and a pop may share a cycle,
// limited only by the two-entry queues between the decode stages.
// Reset (rst, synchronous, active high) empties both queues and returns
// the bank registers to their power-on values, with the ROM bank at 1.
`default_nettype none

module handheld_bus_address_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Address side, written like a queue.
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [hbad_pkg::ADDR_W-1:0]       bus_address,
  // Result side, read like a queue.
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [3:0]                             region,
  output logic [hbad_pkg::OFFSET_W-1:0]          offset,
  output logic                                   mapped,
  // Register write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hbad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hbad_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hbad_pkg::cfg_t  cfg;
  hbad_pkg::item_t front_item;
  hbad_pkg::item_t back_item;
  logic            queue_wr;
  logic            queue_full;
  logic            queue_valid;
  logic            back_take;

  // Bank controller and boot overlay registers. Writes are expected only
  // while no address is in flight, so the front stage reads them directly.
  hbad_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The front stage picks the region and resolves every register-dependent
  // choice: boot overlay, which ROM bank applies, and how external RAM wraps.
  hbad_front u_front (
    .push        (push),
    .full        (full),
    .bus_address (bus_address),
    .cfg         (cfg),
    .queue_full  (queue_full),
    .queue_wr    (queue_wr),
    .queue_item  (front_item)
  );

  // A short queue decouples the classifier from the offset builder so that
  // a stalled result reader does not immediately block new addresses.
  hbad_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (queue_wr),
    .wr_item (front_item),
    .full    (queue_full),
    .rd      (back_take),
    .rd_item (back_item),
    .valid   (queue_valid)
  );

  // The back stage assembles the byte offset (bank concatenation or the
  // external RAM bank remainder) and holds finished results for the reader.
  hbad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (queue_valid),
    .in_item  (back_item),
    .in_take  (back_take),
    .pop      (pop),
    .empty    (empty),
    .region   (region),
    .offset   (offset),
    .mapped   (mapped)
  );

endmodule

`default_nettype wire

// File: design/hbad_regs.sv
`default_nettype none

module hbad_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hbad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hbad_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hbad_pkg::cfg_t                         cfg
);

  hbad_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.controller_kind <= '0;
      regs.bank_mode       <= 1'b0;
      regs.rom_bank        <= hbad_pkg::ROM_BANK_W'(1);
      regs.ram_bank        <= '0;
      regs.ram_bank_count  <= '0;
      regs.boot_size       <= '0;
      regs.boot_enabled    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbad_pkg::CFG_CONTROLLER_KIND: regs.controller_kind <= cfg_data[1:0];
        hbad_pkg::CFG_BANK_MODE:       regs.bank_mode       <= cfg_data[0];
        hbad_pkg::CFG_ROM_BANK:
          regs.rom_bank <= cfg_data[hbad_pkg::ROM_BANK_W-1:0];
        hbad_pkg::CFG_RAM_BANK:
          regs.ram_bank <= cfg_data[hbad_pkg::RAM_BANK_W-1:0];
        hbad_pkg::CFG_RAM_BANK_COUNT:
          regs.ram_bank_count <= cfg_data[hbad_pkg::RAM_COUNT_W-1:0];
        hbad_pkg::CFG_BOOT_SIZE:       regs.boot_size       <= cfg_data[11:0];
        hbad_pkg::CFG_BOOT_ENABLED:    regs.boot_enabled    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/hbad_front.sv
`default_nettype none

module hbad_front (
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [hbad_pkg::ADDR_W-1:0]  bus_address,
  input  wire hbad_pkg::cfg_t               cfg,
  input  wire logic                         queue_full,
  output logic                              queue_wr,
  output hbad_pkg::item_t                   queue_item
);

  logic [hbad_pkg::RAM_COUNT_W-1:0] count_sat;

  assign full     = queue_full;
  assign queue_wr = push && !queue_full;

  assign count_sat = (cfg.ram_bank_count > hbad_pkg::RAM_COUNT_MAX) ?
                     hbad_pkg::RAM_COUNT_MAX : cfg.ram_bank_count;

  always_comb begin
    queue_item.region     = hbad_pkg::REG_PROHIBITED;
    queue_item.op         = hbad_pkg::OP_UNMAPPED;
    queue_item.bank       = '0;
    queue_item.count      = '0;
    queue_item.local_addr = '0;
    if (bus_address < hbad_pkg::ADDR_VRAM) begin
      queue_item.local_addr = bus_address;
      if (cfg.boot_enabled && (bus_address < {4'd0, cfg.boot_size})) begin
        queue_item.region = hbad_pkg::REG_BOOT;
        queue_item.op     = hbad_pkg::OP_DIRECT;
      end else if (!bus_address[hbad_pkg::ROM_PAGE_W]) begin
        queue_item.region = hbad_pkg::REG_ROM;
        if ((cfg.controller_kind == hbad_pkg::CTRL_TYPE_ONE) && cfg.bank_mode) begin
          queue_item.op   = hbad_pkg::OP_ROM_BANK;
          queue_item.bank = cfg.rom_bank & hbad_pkg::ROM_LOW_BANK_MASK;
        end else begin
          queue_item.op   = hbad_pkg::OP_DIRECT;
        end
      end else begin
        queue_item.region = hbad_pkg::REG_ROM;
        queue_item.op     = hbad_pkg::OP_ROM_BANK;
        queue_item.bank   = cfg.rom_bank;
      end
    end else if (bus_address < hbad_pkg::ADDR_EXT_RAM) begin
      queue_item.region     = hbad_pkg::REG_VRAM;
      queue_item.op         = hbad_pkg::OP_DIRECT;
      queue_item.local_addr = {3'd0, bus_address[12:0]};
    end else if (bus_address < hbad_pkg::ADDR_WORK_RAM) begin
      queue_item.region = hbad_pkg::REG_EXT_RAM;
      if (cfg.controller_kind == hbad_pkg::CTRL_TYPE_TWO) begin
        queue_item.op         = hbad_pkg::OP_DIRECT;
        queue_item.local_addr = {7'd0, bus_address[8:0]};
      end else if (count_sat != '0) begin
        queue_item.op         = hbad_pkg::OP_EXT_BANK;
        queue_item.bank       = {{(hbad_pkg::ROM_BANK_W - hbad_pkg::RAM_BANK_W){1'b0}},
                                 cfg.ram_bank};
        queue_item.count      = count_sat;
        queue_item.local_addr = {3'd0, bus_address[12:0]};
      end
    end else if (bus_address < hbad_pkg::ADDR_OAM) begin
      // Work RAM and its echo share the low 13 address bits.
      queue_item.region     = hbad_pkg::REG_WORK_RAM;
      queue_item.op         = hbad_pkg::OP_DIRECT;
      queue_item.local_addr = {3'd0, bus_address[12:0]};
    end else if (bus_address < hbad_pkg::ADDR_PROHIBITED) begin
      queue_item.region     = hbad_pkg::REG_OAM;
      queue_item.op         = hbad_pkg::OP_DIRECT;
      queue_item.local_addr = {8'd0, bus_address[7:0]};
    end else if (bus_address < hbad_pkg::ADDR_IO) begin
      queue_item.region = hbad_pkg::REG_PROHIBITED;
    end else if (bus_address < hbad_pkg::ADDR_HIGH_RAM) begin
      queue_item.region     = hbad_pkg::REG_IO;
      queue_item.op         = hbad_pkg::OP_DIRECT;
      queue_item.local_addr = {9'd0, bus_address[6:0]};
    end else begin
      queue_item.region     = hbad_pkg::REG_HIGH_RAM;
      queue_item.op         = hbad_pkg::OP_DIRECT;
      queue_item.local_addr = {9'd0, bus_address[6:0]};
    end
  end

endmodule

`default_nettype wire

// File: design/hbad_queue.sv
`default_nettype none

module hbad_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire hbad_pkg::item_t  wr_item,
  output logic                  full,
  input  wire logic             rd,
  output hbad_pkg::item_t       rd_item,
  output logic                  valid
);

  hbad_pkg::item_t                 entries [hbad_pkg::QUEUE_DEPTH];
  logic [hbad_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [hbad_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [hbad_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_wr;
  logic                             do_rd;

  localparam logic [hbad_pkg::QUEUE_PTR_W-1:0] LastPtr =
    hbad_pkg::QUEUE_PTR_W'(hbad_pkg::QUEUE_DEPTH - 1);
  localparam logic [hbad_pkg::QUEUE_CNT_W-1:0] FullCount =
    hbad_pkg::QUEUE_CNT_W'(hbad_pkg::QUEUE_DEPTH);

  assign full    = (count == FullCount);
  assign valid   = (count != '0);
  assign rd_item = entries[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/hbad_back.sv
`default_nettype none

module hbad_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire hbad_pkg::item_t                in_item,
  output logic                                in_take,
  input  wire logic                           pop,
  output logic                                empty,
  output logic [3:0]                          region,
  output logic [hbad_pkg::OFFSET_W-1:0]       offset,
  output logic                                mapped
);

  hbad_pkg::result_t                results [hbad_pkg::OUT_DEPTH];
  hbad_pkg::result_t                built;
  logic [hbad_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [hbad_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic [hbad_pkg::OUT_CNT_W-1:0]   count;
  logic                             do_rd;

  localparam logic [hbad_pkg::OUT_PTR_W-1:0] LastPtr =
    hbad_pkg::OUT_PTR_W'(hbad_pkg::OUT_DEPTH - 1);
  localparam logic [hbad_pkg::OUT_CNT_W-1:0] FullCount =
    hbad_pkg::OUT_CNT_W'(hbad_pkg::OUT_DEPTH);

  // Build the byte offset from the classified access.
  always_comb begin
    built.region = in_item.region;
    built.mapped = 1'b1;
    case (in_item.op)
      hbad_pkg::OP_DIRECT: begin
        built.offset = {{(hbad_pkg::OFFSET_W - hbad_pkg::ADDR_W){1'b0}},
                        in_item.local_addr};
      end
      hbad_pkg::OP_ROM_BANK: begin
        built.offset = {in_item.bank, in_item.local_addr[hbad_pkg::ROM_PAGE_W-1:0]};
      end
      hbad_pkg::OP_EXT_BANK: begin
        built.offset = {{(hbad_pkg::OFFSET_W - hbad_pkg::RAM_BANK_W
                          - hbad_pkg::RAM_PAGE_W){1'b0}},
                        hbad_pkg::ram_bank_wrap(in_item.bank[hbad_pkg::RAM_BANK_W-1:0],
                                                in_item.count),
                        in_item.local_addr[hbad_pkg::RAM_PAGE_W-1:0]};
      end
      default: begin
        built.offset = '0;
        built.mapped = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && (count != FullCount);
  assign empty   = (count == '0);
  assign do_rd   = pop && !empty;
  assign region  = results[rd_ptr].region;
  assign offset  = results[rd_ptr].offset;
  assign mapped  = results[rd_ptr].mapped;

  always_ff @(posedge clk) begin
    if (in_take) begin
      results[wr_ptr] <= built;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_take) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({in_take, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/hbad_checker.sv
`default_nettype none
`include "handheld_bus_address_decoder_defines.svh"

module hbad_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [3:0]                    region,
  input wire logic [hbad_pkg::OFFSET_W-1:0] offset,
  input wire logic                          mapped
);

  logic result_waiting;
  logic gap_result;
  logic may_be_unmapped;

  assign result_waiting  = !empty && !pop;
  assign gap_result      = !empty && (region == hbad_pkg::REG_PROHIBITED);
  assign may_be_unmapped = (region == hbad_pkg::REG_PROHIBITED) ||
                           (region == hbad_pkg::REG_EXT_RAM);

  `HBAD_ASSERT_AFTER_RESET(a_empty_after_reset, clk, rst, empty)

  `HBAD_ASSERT_NEXT(a_result_held, clk, rst, result_waiting, !empty && $stable({region, offset, mapped}))

  `HBAD_ASSERT_IMPL(a_gap_unmapped, clk, rst, gap_result, !mapped && (offset == '0))

  `HBAD_ASSERT_IMPL(a_unmapped_region, clk, rst, !empty && !mapped, may_be_unmapped)

endmodule

bind handheld_bus_address_decoder hbad_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .region (region),
  .offset (offset),
  .mapped (mapped)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the handheld bus address decoder.
// A driver process offers CPU bus addresses from a backlog, a receiver process
// pops decoded results, and a monitor predicts each decode at the moment an
// address is accepted, then compares every popped result against the oldest
// prediction. Bank, controller and boot settings are rewritten between phases,
// only once the block has gone quiet.
module tb_top;
  import hbad_pkg::*;

  // Controller code that the package leaves unnamed.
  localparam logic [1:0] CTRL_NONE   = 2'd0;
  // Register index that decodes to nothing; a write there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = 3'd7;
  // Start of the switchable ROM window.
  localparam logic [ADDR_W-1:0] ROM_HIGH_START = 16'h4000;
  localparam int LONG_HOLD = 300;
  localparam int RAND_PHASES = 26;
  localparam int PHASE_ITEMS = 50;

  logic clk;
  logic rst = 1'b1;

  logic                   push = 1'b0;
  logic                   full;
  logic [ADDR_W-1:0]      bus_address = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [3:0]             region;
  logic [OFFSET_W-1:0]    offset;
  logic                   mapped;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  handheld_bus_address_decoder uut (
    .clk, .rst, .push, .full, .bus_address, .empty, .pop,
    .region, .offset, .mapped, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Addresses waiting to be offered, and the decodes still owed by the block.
  logic [ADDR_W-1:0] addr_backlog[$];
  result_t           owed_decodes[$];

  // Shadow copy of the bank registers, updated on every accepted write.
  logic [1:0]             shadow_kind;
  logic                   shadow_mode;
  logic [ROM_BANK_W-1:0]  shadow_rom_bank;
  logic [RAM_BANK_W-1:0]  shadow_ram_bank;
  logic [RAM_COUNT_W-1:0] shadow_ram_count;
  logic [11:0]            shadow_boot_size;
  logic                   shadow_boot_on;

  int   items_queued = 0;
  int   items_accepted = 0;
  int   results_checked = 0;
  int   reg_writes = 0;
  int   setups = 0;
  int   errors = 0;
  logic idle_on = 1'b0;
  logic took_item = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic long_hold_done = 1'b0;
  logic [11:0] boot_len = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected decode of one bus address under the current shadow registers.
  function automatic result_t decode_address(input logic [ADDR_W-1:0] a);
    result_t     r;
    int unsigned la;
    int unsigned banks;
    la = a;
    r.region = REG_PROHIBITED;
    r.offset = '0;
    r.mapped = 1'b1;
    if (a < ADDR_VRAM) begin
      r.region = REG_ROM;
      if (shadow_boot_on && la < shadow_boot_size) begin
        // The boot ROM sits on top of the cartridge while it is mapped.
        r.region = REG_BOOT;
        r.offset = OFFSET_W'(la);
      end else if (a < ROM_HIGH_START) begin
        // Type one in mode 1 banks the fixed area with the upper bank bits.
        if (shadow_kind == CTRL_TYPE_ONE && shadow_mode)
          r.offset = OFFSET_W'(((shadow_rom_bank & 9'h060) % MAX_ROM_BANKS) * 32'h4000 + la);
        else
          r.offset = OFFSET_W'(la);
      end else begin
        r.offset = OFFSET_W'((shadow_rom_bank % MAX_ROM_BANKS) * 32'h4000 + la - 32'h4000);
      end
    end else if (a < ADDR_EXT_RAM) begin
      r.region = REG_VRAM;
      r.offset = OFFSET_W'(la - ADDR_VRAM);
    end else if (a < ADDR_WORK_RAM) begin
      r.region = REG_EXT_RAM;
      if (shadow_kind == CTRL_TYPE_TWO) begin
        r.offset = OFFSET_W'((la - ADDR_EXT_RAM) % 32'h200);
      end else begin
        // Bank counts past the parameter saturate; no banks means no backing byte.
        banks = (shadow_ram_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : shadow_ram_count;
        if (banks == 0)
          r.mapped = 1'b0;
        else
          r.offset = OFFSET_W'((la - ADDR_EXT_RAM + shadow_ram_bank * 32'h2000)
                               % (banks * 32'h2000));
      end
    end else if (a < ADDR_ECHO_RAM) begin
      r.region = REG_WORK_RAM;
      r.offset = OFFSET_W'(la - ADDR_WORK_RAM);
    end else if (a < ADDR_OAM) begin
      // Echo RAM folds back onto work RAM.
      r.region = REG_WORK_RAM;
      r.offset = OFFSET_W'(la - ADDR_ECHO_RAM);
    end else if (a < ADDR_PROHIBITED) begin
      r.region = REG_OAM;
      r.offset = OFFSET_W'(la - ADDR_OAM);
    end else if (a < ADDR_IO) begin
      r.mapped = 1'b0;
    end else if (a < ADDR_HIGH_RAM) begin
      r.region = REG_IO;
      r.offset = OFFSET_W'(la - ADDR_IO);
    end else begin
      r.region = REG_HIGH_RAM;
      r.offset = OFFSET_W'(la - ADDR_HIGH_RAM);
    end
    return r;
  endfunction

  // Monitor: everything is sampled at the rising edge. A popped result is
  // checked before the same edge's accepted address is predicted, so a result
  // can never be matched against its own address in the same cycle.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      shadow_kind      <= CTRL_NONE;
      shadow_mode      <= 1'b0;
      shadow_rom_bank  <= 9'd1;
      shadow_ram_bank  <= '0;
      shadow_ram_count <= '0;
      shadow_boot_size <= '0;
      shadow_boot_on   <= 1'b0;
      took_item        <= 1'b0;
    end else begin
      took_item <= push && !full;
      if (pop && !empty) begin
        if (owed_decodes.size() == 0) begin
          $error("unexpected result: region %0d offset 0x%0h mapped %0b",
                 region, offset, mapped);
          errors++;
        end else begin
          want = owed_decodes.pop_front();
          if (region !== want.region) begin
            $error("region: expected %0d, got %0d", want.region, region);
            errors++;
          end
          if (offset !== want.offset) begin
            $error("offset: expected 0x%0h, got 0x%0h", want.offset, offset);
            errors++;
          end
          if (mapped !== want.mapped) begin
            $error("mapped: expected %0b, got %0b", want.mapped, mapped);
            errors++;
          end
          results_checked++;
        end
      end
      if (push && !full) begin
        owed_decodes.push_back(decode_address(bus_address));
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_CONTROLLER_KIND: shadow_kind      <= cfg_data[1:0];
          CFG_BANK_MODE:       shadow_mode      <= cfg_data[0];
          CFG_ROM_BANK:        shadow_rom_bank  <= cfg_data[ROM_BANK_W-1:0];
          CFG_RAM_BANK:        shadow_ram_bank  <= cfg_data[RAM_BANK_W-1:0];
          CFG_RAM_BANK_COUNT:  shadow_ram_count <= cfg_data[RAM_COUNT_W-1:0];
          CFG_BOOT_SIZE:       shadow_boot_size <= cfg_data[11:0];
          CFG_BOOT_ENABLED:    shadow_boot_on   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Driver: an offered address is held until the monitor saw it accepted.
  // Only then may a random idle gap start or the next address go out.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || took_item) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (addr_backlog.size() == 0) begin
        push <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 15);
        push <= 1'b0;
      end else begin
        push        <= 1'b1;
        bus_address <= addr_backlog.pop_front();
      end
    end
  end

  // Receiver: pops whenever it is not stalling. Once, with plenty of traffic
  // still queued, it holds off for a long stretch so that both internal queues
  // fill and the block has to push back on the sender with full.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!long_hold_done && results_checked >= 200 && addr_backlog.size() > 20) begin
      long_hold_done <= 1'b1;
      stall_left = LONG_HOLD - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // One register write; valid stays up so that back-to-back writes never
  // drop it in between. The caller lowers it after the last write.
  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register. Bits above each register's width carry noise that
  // the block has to drop. The write to the unused index goes last, so that a
  // block which wrongly stores it cannot hide the fault behind a later write.
  task automatic apply_setup(input logic [1:0] kind, input logic mode,
                             input logic [8:0] rbank, input logic [3:0] xbank,
                             input logic [4:0] xcount, input logic [11:0] blen,
                             input logic ben);
    cfg_put(CFG_CONTROLLER_KIND, 12'({$urandom(), kind}));
    cfg_put(CFG_BANK_MODE,       12'({$urandom(), mode}));
    cfg_put(CFG_ROM_BANK,        12'({$urandom(), rbank}));
    cfg_put(CFG_RAM_BANK,        12'({$urandom(), xbank}));
    cfg_put(CFG_RAM_BANK_COUNT,  12'({$urandom(), xcount}));
    cfg_put(CFG_BOOT_SIZE,       blen);
    cfg_put(CFG_BOOT_ENABLED,    12'({$urandom(), ben}));
    cfg_put(CFG_NO_SUCH_REG,     12'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
    boot_len = blen;
    setups++;
  endtask

  task automatic queue_address(input logic [ADDR_W-1:0] a);
    addr_backlog.push_back(a);
    items_queued++;
  endtask

  // Waits until every queued address went in and every decode came back,
  // then lets the pipeline settle before registers change again.
  task automatic wait_drained();
    while (items_accepted != items_queued || results_checked != items_accepted)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random addresses: a good share uniform over the whole space, the rest aimed at
  // the boot area and its edge, ROM, external RAM, the top page and region boundaries.
  function automatic logic [ADDR_W-1:0] pick_address(input logic [11:0] blen);
    logic [ADDR_W-1:0] base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom());
      4: return 16'($urandom_range(0, 16'h0FFF));
      5: return 16'(blen) - 16'($urandom_range(0, 1));
      6: return ADDR_EXT_RAM + 16'($urandom_range(0, 16'h1FFF));
      7: return ADDR_OAM + 16'($urandom_range(0, 16'h01FF));
      8: begin
        case ($urandom_range(0, 9))
          0: base = '0;
          1: base = ROM_HIGH_START;
          2: base = ADDR_VRAM;
          3: base = ADDR_EXT_RAM;
          4: base = ADDR_WORK_RAM;
          5: base = ADDR_ECHO_RAM;
          6: base = ADDR_OAM;
          7: base = ADDR_PROHIBITED;
          8: base = ADDR_IO;
          default: base = ADDR_HIGH_RAM;
        endcase
        // Zero minus one lands on the very top address.
        return base - 16'($urandom_range(0, 1));
      end
      default: return 16'($urandom_range(0, 16'h7FFF));
    endcase
  endfunction

  initial begin : stimulus
    logic [ADDR_W-1:0] edges_reset[] = '{
      16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
      16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F,
      16'hFEA0, 16'hFEFF, 16'hFF00, 16'hFF7F, 16'hFF80, 16'hFFFF};
    logic [ADDR_W-1:0] edges_banked[] = '{
      16'h08FF, 16'h0900, 16'h3FFF, 16'h4000, 16'h7FFF, 16'hA000, 16'hBFFF};
    logic [4:0]  xcount;
    logic [11:0] blen;
    logic [8:0]  rbank;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Power-on settings: every region boundary, with no RAM fitted, so the
    // whole external RAM window must come back unmapped.
    foreach (edges_reset[i]) queue_address(edges_reset[i]);
    wait_drained();

    // A 2304-byte boot ROM on top of a type-one cartridge in mode 1 with the top
    // ROM bank, last RAM bank and a bank count beyond the parameter.
    apply_setup(CTRL_TYPE_ONE, 1'b1, 9'h1FF, 4'hF, 5'd31, 12'd2304, 1'b1);
    foreach (edges_banked[i]) queue_address(edges_banked[i]);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 5)
        0: xcount = 5'd0;
        1: xcount = 5'd1;
        2: xcount = 5'd16;
        3: xcount = 5'd31;
        default: xcount = 5'($urandom());
      endcase
      case (p % 4)
        0: blen = 12'd0;
        1: blen = 12'd2304;
        2: blen = 12'hFFF;
        default: blen = 12'($urandom());
      endcase
      rbank = (p % 3 == 0) ? 9'h1FF : (p % 3 == 1) ? 9'd0 : 9'($urandom());
      // Cycling the controller code also reaches the unused code three.
      apply_setup(2'(p % 4), 1'((p / 4) % 2), rbank,
                  (p % 4 == 3) ? 4'hF : 4'($urandom()), xcount, blen,
                  $urandom_range(0, 3) != 0);
      // A few phases run flat out, and the closing phases have no idling at all.
      idle_on = (p < RAND_PHASES - 3) && (p % 5 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_address(pick_address(boot_len));
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (owed_decodes.size() != 0) begin
      $error("%0d expected results never arrived", owed_decodes.size());
      errors++;
    end
    $display("Decoded %0d bus addresses under %0d register setups (%0d register writes),",
             results_checked, setups, reg_writes);
    $display("including one %0d-cycle result stall that backed up the address side.",
             LONG_HOLD);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Far beyond the slowest legal run, long stall and register writes included.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
